FILE: hw/rtl/bsa_pkg.sv
// Shared types, codes and slice lookahead functions for the bit-slice ALU.
`default_nettype none
package bsa_pkg;

	localparam int unsigned WordW = 16;
	localparam int unsigned RegCount = 16;
	localparam int unsigned RegAddrW = 4;

	typedef enum logic [2:0] {
		SRC_AQ = 3'd0,
		SRC_AB = 3'd1,
		SRC_ZQ = 3'd2,
		SRC_ZB = 3'd3,
		SRC_ZA = 3'd4,
		SRC_DA = 3'd5,
		SRC_DQ = 3'd6,
		SRC_D0 = 3'd7
	} src_t;

	typedef enum logic [2:0] {
		FN_ADD   = 3'd0,
		FN_SUBR  = 3'd1,
		FN_SUBS  = 3'd2,
		FN_OR    = 3'd3,
		FN_AND   = 3'd4,
		FN_NOTRS = 3'd5,
		FN_XOR   = 3'd6,
		FN_XNOR  = 3'd7
	} fn_t;

	typedef enum logic [2:0] {
		DST_QREG = 3'd0,
		DST_NOP  = 3'd1,
		DST_RAMA = 3'd2,
		DST_RAMF = 3'd3,
		DST_RAMQD = 3'd4,
		DST_RAMD = 3'd5,
		DST_RAMQU = 3'd6,
		DST_RAMU = 3'd7
	} dst_t;

	typedef enum logic [1:0] {
		KIND_OR   = 2'd1,
		KIND_AND  = 2'd2,
		KIND_XNOR = 2'd3
	} kind_t;

	typedef struct packed {
		logic [2:0]          source_pair;
		logic [2:0]          alu_function;
		logic [2:0]          destination;
		logic [RegAddrW-1:0] reg_a;
		logic [RegAddrW-1:0] reg_b;
		logic                cycle_shift;
		logic [WordW-1:0]    data_in;
		logic                carry_lsb;
		logic                addr_load;
	} req_t;

	typedef struct packed {
		logic zero;
		logic negative;
		logic carry;
		logic overflow;
		logic nibble;
		logic byte_c;
	} flags_t;

	typedef struct packed {
		logic [WordW-1:0] y;
		flags_t           flags;
	} res_t;

	typedef struct packed {
		logic             rf_we;
		logic [WordW-1:0] rf_data;
		logic             q_we;
		logic [WordW-1:0] q_data;
	} wr_t;

	function automatic logic slice_carry(kind_t kind, logic [3:0] x, logic [3:0] y, logic c);
		logic [3:0] p;
		logic [3:0] g;
		logic t;
		logic res;
		p = x | y;
		g = x & y;
		t = g[3] | (p[3] & g[2]) | (p[3] & p[2] & g[1])
			| ((&p) & (g[0] | ~c));
		case (kind)
			KIND_OR:  res = (p != 4'hf) | c;
			KIND_AND: res = (g != 4'h0) | c;
			default:  res = ~t;
		endcase
		return res;
	endfunction

	function automatic logic xnor_overflow(logic [3:0] x, logic [3:0] y, logic c);
		logic [3:0] np;
		logic [3:0] ng;
		logic a;
		logic b;
		np = ~(x | y);
		ng = ~(x & y);
		a = np[2] | (ng[2] & np[1]) | (ng[2] & ng[1] & np[0])
			| (ng[2] & ng[1] & ng[0] & c);
		b = np[3] | (ng[3] & np[2]) | (ng[3] & ng[2] & np[1])
			| (ng[3] & ng[2] & ng[1] & np[0])
			| (ng[3] & ng[2] & ng[1] & ng[0] & c);
		return a ^ b;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/bsa_ram.sv
// Generic RAM with one write port and two registered read ports.
`default_nettype none
module bsa_ram #(
	parameter int unsigned Width = 16,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr_a,
	input  logic [$clog2(Depth)-1:0] raddr_b,
	output logic [Width-1:0]         rdata_a,
	output logic [Width-1:0]         rdata_b
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/bsa_alu.sv
// Operand select, ALU function, flag logic, address load and destination shifter.
`default_nettype none
module bsa_alu (
	input  bsa_pkg::req_t            req,
	input  logic [bsa_pkg::WordW-1:0] a_val,
	input  logic [bsa_pkg::WordW-1:0] b_val,
	input  logic [bsa_pkg::WordW-1:0] q_val,
	input  logic                      exact,
	output bsa_pkg::res_t             res,
	output bsa_pkg::wr_t              wr
);
	import bsa_pkg::*;

	logic [WordW-1:0] r;
	logic [WordW-1:0] s;
	logic [WordW-1:0] x;
	logic [WordW-1:0] xl;
	logic [WordW-1:0] ya;
	logic [WordW:0]   sum;
	logic [WordW-1:0] f;
	logic [WordW-1:0] fm;
	logic             arith;
	kind_t            kind;
	logic             carry;
	logic             ovf;
	logic             nib;
	logic             pg;
	logic             mid;
	logic             lm_mid;
	logic             lm_carry;
	logic             lm_ovf;
	logic             fill;

	always_comb begin
		unique case (src_t'(req.source_pair))
			SRC_AQ: begin r = a_val; s = q_val; end
			SRC_AB: begin r = a_val; s = b_val; end
			SRC_ZQ: begin r = '0;    s = q_val; end
			SRC_ZB: begin r = '0;    s = b_val; end
			SRC_ZA: begin r = '0;    s = a_val; end
			SRC_DA: begin r = req.data_in; s = a_val; end
			SRC_DQ: begin r = req.data_in; s = q_val; end
			default: begin r = req.data_in; s = '0; end
		endcase
	end

	always_comb begin
		arith = 1'b0;
		x = r;
		ya = s;
		f = '0;
		xl = r;
		kind = KIND_OR;
		unique case (fn_t'(req.alu_function))
			FN_ADD:   begin arith = 1'b1; end
			FN_SUBR:  begin arith = 1'b1; x = ~r; end
			FN_SUBS:  begin arith = 1'b1; ya = ~s; end
			FN_OR:    begin f = r | s;  kind = KIND_OR; end
			FN_AND:   begin f = r & s;  kind = KIND_AND; end
			FN_NOTRS: begin f = ~r & s; kind = KIND_AND; xl = ~r; end
			FN_XOR:   begin f = r ^ s;  kind = KIND_XNOR; xl = ~r; end
			default:  begin f = ~(r ^ s); kind = KIND_XNOR; end
		endcase
		sum = {1'b0, x} + {1'b0, ya} + {{WordW{1'b0}}, req.carry_lsb};
		carry = 1'b0;
		ovf = 1'b0;
		nib = 1'b0;
		pg = 1'b0;
		mid = 1'b0;
		if (arith) begin
			f = sum[WordW-1:0];
			carry = sum[WordW];
			nib = sum[4] ^ x[4] ^ ya[4];
			pg = sum[8] ^ x[8] ^ ya[8];
			ovf = carry ^ sum[15] ^ x[15] ^ ya[15];
		end else if (exact) begin
			nib = slice_carry(kind, xl[3:0], s[3:0], req.carry_lsb);
			pg = slice_carry(kind, xl[7:4], s[7:4], nib);
			mid = slice_carry(kind, xl[11:8], s[11:8], pg);
			carry = slice_carry(kind, xl[15:12], s[15:12], mid);
			ovf = (kind == KIND_XNOR) ? xnor_overflow(xl[15:12], s[15:12], mid) : carry;
		end else if (fn_t'(req.alu_function) == FN_OR) begin
			nib = slice_carry(KIND_OR, r[3:0], s[3:0], req.carry_lsb);
			pg = slice_carry(KIND_OR, r[7:4], s[7:4], nib);
		end
	end

	always_comb begin
		fm = f;
		lm_mid = 1'b0;
		lm_carry = carry;
		lm_ovf = ovf;
		if (req.addr_load) begin
			if (!req.alu_function[2]) begin
				fm = {b_val[15:8], f[7:0]};
				lm_mid = slice_carry(KIND_OR, r[11:8], s[11:8], pg);
				lm_carry = slice_carry(KIND_OR, r[15:12], s[15:12], lm_mid);
				lm_ovf = lm_carry;
			end else begin
				fm = {~b_val[15:8], f[7:0]};
				lm_mid = slice_carry(KIND_XNOR, r[11:8], s[11:8], pg);
				lm_carry = slice_carry(KIND_XNOR, r[15:12], s[15:12], lm_mid);
				lm_ovf = xnor_overflow(r[15:12], s[15:12], lm_mid);
			end
		end
	end

	always_comb begin
		res.y = fm;
		res.flags.zero = (fm == '0);
		res.flags.negative = fm[WordW-1];
		res.flags.carry = lm_carry;
		res.flags.overflow = lm_ovf;
		res.flags.nibble = nib;
		res.flags.byte_c = pg;
		wr.rf_we = 1'b1;
		wr.rf_data = fm;
		wr.q_we = 1'b0;
		wr.q_data = fm;
		fill = 1'b0;
		unique case (dst_t'(req.destination))
			DST_QREG: begin
				wr.rf_we = 1'b0;
				wr.q_we = 1'b1;
			end
			DST_NOP: begin
				wr.rf_we = 1'b0;
			end
			DST_RAMA: begin
				res.y = a_val;
			end
			DST_RAMF: begin
				wr.rf_data = fm;
			end
			DST_RAMQD: begin
				fill = req.cycle_shift ? req.carry_lsb : lm_carry;
				wr.rf_data = {fill, fm[WordW-1:1]};
				wr.q_we = 1'b1;
				wr.q_data = {~fm[0], q_val[WordW-1:1]};
			end
			DST_RAMD: begin
				fill = req.cycle_shift ? fm[0] : req.carry_lsb;
				wr.rf_data = {fill, fm[WordW-1:1]};
			end
			DST_RAMQU: begin
				wr.rf_data = {fm[WordW-2:0], q_val[WordW-1]};
				wr.q_we = 1'b1;
				wr.q_data = {q_val[WordW-2:0], ~req.carry_lsb};
			end
			default: begin
				fill = req.cycle_shift ? fm[WordW-1] : req.carry_lsb;
				wr.rf_data = {fm[WordW-2:0], fill};
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: hw/rtl/bit_slice_alu_16bit_top.sv
// Top level of the 16-bit bit-slice ALU: request stage, register file, Q and result register.
// A request and its RAM reads are registered into stage one when it is taken; the ALU result is
// registered into the result register when stage one commits.
// Throughput: one request per cycle unless out_ready stalls; the register file RAM reads at
// the request edge and writes when the request moves into the result register, with a bypass
// between. Reset clears the stage valids, the Q register, the flag mode and the register file
// valid bits, so every register reads as zero until written; no clearing pass.
`default_nettype none
module bit_slice_alu_16bit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  source_pair,
	input  logic [2:0]  alu_function,
	input  logic [2:0]  destination,
	input  logic [3:0]  reg_a,
	input  logic [3:0]  reg_b,
	input  logic        cycle_shift,
	input  logic [15:0] data_in,
	input  logic        carry_lsb,
	input  logic        addr_load,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] y_out,
	output logic        zero_flag,
	output logic        negative_flag,
	output logic        carry_flag,
	output logic        overflow_flag,
	output logic        nibble_carry,
	output logic        byte_carry
);
	import bsa_pkg::*;

	logic                exact_q;
	logic [WordW-1:0]    qreg_q;
	logic [RegCount-1:0] rf_vld_q;
	logic                v_s1;
	req_t                req_s1;
	logic                a_vld_s1;
	logic                b_vld_s1;
	logic                fwd_a_s1;
	logic                fwd_b_s1;
	logic [WordW-1:0]    fwd_data_s1;
	logic                out_valid_q;
	res_t                res_q;
	logic                advance;
	logic                commit;
	logic                in_acc;
	logic                ram_we;
	logic [WordW-1:0]    rd_a;
	logic [WordW-1:0]    rd_b;
	logic [WordW-1:0]    a_val;
	logic [WordW-1:0]    b_val;
	res_t                res;
	wr_t                 wr;

	assign cfg_ready = 1'b1;
	assign advance = !out_valid_q || out_ready;
	assign commit = v_s1 && advance;
	assign in_ready = !v_s1 || advance;
	assign in_acc = in_valid && in_ready;
	assign ram_we = commit && wr.rf_we;

	bsa_ram #(
		.Width(WordW),
		.Depth(RegCount)
	) u_rf (
		.clk(clk),
		.we(ram_we),
		.waddr(req_s1.reg_b),
		.wdata(wr.rf_data),
		.re(in_acc),
		.raddr_a(reg_a),
		.raddr_b(reg_b),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	assign a_val = fwd_a_s1 ? fwd_data_s1 : (a_vld_s1 ? rd_a : '0);
	assign b_val = fwd_b_s1 ? fwd_data_s1 : (b_vld_s1 ? rd_b : '0);

	bsa_alu u_alu (
		.req(req_s1),
		.a_val(a_val),
		.b_val(b_val),
		.q_val(qreg_q),
		.exact(exact_q),
		.res(res),
		.wr(wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exact_q <= 1'b0;
			qreg_q <= '0;
			rf_vld_q <= '0;
			v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				exact_q <= cfg_data;
			end
			if (commit && wr.q_we) begin
				qreg_q <= wr.q_data;
			end
			if (ram_we) begin
				rf_vld_q[req_s1.reg_b] <= 1'b1;
			end
			v_s1 <= in_acc || (v_s1 && !advance);
			out_valid_q <= commit || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1 <= '{source_pair: source_pair, alu_function: alu_function,
				destination: destination, reg_a: reg_a, reg_b: reg_b,
				cycle_shift: cycle_shift, data_in: data_in, carry_lsb: carry_lsb,
				addr_load: addr_load};
			a_vld_s1 <= rf_vld_q[reg_a];
			b_vld_s1 <= rf_vld_q[reg_b];
			fwd_a_s1 <= ram_we && (req_s1.reg_b == reg_a);
			fwd_b_s1 <= ram_we && (req_s1.reg_b == reg_b);
			fwd_data_s1 <= wr.rf_data;
		end
		if (commit) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign y_out = res_q.y;
	assign zero_flag = res_q.flags.zero;
	assign negative_flag = res_q.flags.negative;
	assign carry_flag = res_q.flags.carry;
	assign overflow_flag = res_q.flags.overflow;
	assign nibble_carry = res_q.flags.nibble;
	assign byte_carry = res_q.flags.byte_c;

	a_we_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> v_s1)
		else $error("register file written with no request in stage one");

	a_acc_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> v_s1)
		else $error("accepted request missing from stage one");

	a_bypass_a: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && ram_we && req_s1.reg_b == reg_a) |=> fwd_a_s1)
		else $error("A operand bypass not taken for same-edge write");

	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q)
		else $error("committed request did not reach result register");

endmodule
`default_nettype wire
